// ===== hdl/fhdm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the max-frequency heap table.
// No dependencies.
package fhdm_pkg;

    localparam int ENTRIES_DEF    = 1024;
    localparam int COUNT_BITS_DEF = 16;
    localparam int KEY_BITS       = 32;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEL = 1'b1;

endpackage

// ===== hdl/fhdm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on fhdm_pkg.
interface fhdm_req_if
    import fhdm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [KEY_BITS-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface fhdm_rsp_if #(
    parameter int COUNT_BITS = 16,
    parameter int LIVE_BITS  = 11
) ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] freq;
    logic [LIVE_BITS-1:0]  removed;
    logic                  full_res;
    logic [LIVE_BITS-1:0]  live;

    modport source (output valid, output freq, output removed, output full_res,
                    output live, input ready);
    modport sink   (input valid, input freq, input removed, input full_res,
                    input live, output ready);
endinterface

// ===== hdl/frequency_heap_delete_max.sv =====
`timescale 1ns / 1ps
// Max-frequency table: max-heap of {value, count} in one memory, values found by linear scan.
// An add scans the live slots for the value, then climbs the heap; a delete removes
// the root while its count equals the maximum, sinking the last slot down each time.
// One item at a time; the memory's single read port sets the pace.
// Reset clears the live count and control; memory contents need no clearing.
// Depends on fhdm_pkg and fhdm_if.
module frequency_heap_delete_max
    import fhdm_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    fhdm_req_if.sink   req,
    fhdm_rsp_if.source rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int XW = AW + 2;
    localparam logic [LW-1:0] FULL_LIVE = LW'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_UP_RD, S_UP_CMP,
        S_ROOT_RD, S_ROOT_CMP, S_LAST_GET, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DONE
    } state_t;

    slot_t mem [ENTRIES];
    slot_t rd_data;
    logic  rd_en;
    logic  [AW-1:0] rd_addr;
    logic  wr_en;
    logic  [AW-1:0] wr_addr;
    slot_t wr_data;

    state_t                state_reg, state_next;
    logic [LW-1:0]         live_reg, live_next;
    logic [LW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         pos_reg, pos_next;
    slot_t                 cur_reg, cur_next;
    slot_t                 lsl_reg, lsl_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [COUNT_BITS-1:0] maxc_reg, maxc_next;
    logic                  first_reg, first_next;
    logic [COUNT_BITS-1:0] freq_reg, freq_next;
    logic [LW-1:0]         rem_reg, rem_next;
    logic                  full_reg, full_next;
    logic                  ov_reg, ov_next;
    logic [COUNT_BITS-1:0] ofreq_reg, ofreq_next;
    logic [LW-1:0]         orem_reg, orem_next;
    logic                  ofull_reg, ofull_next;
    logic [LW-1:0]         olive_reg, olive_next;

    logic [AW-1:0] parent;
    logic [XW-1:0] lchild, rchild, nlive;
    logic          r_ok;
    slot_t         big;
    logic [AW-1:0] big_pos;
    logic [LW-1:0] last;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    assign parent = AW'((pos_reg - AW'(1)) >> 1);
    assign lchild = XW'({pos_reg, 1'b1});
    assign rchild = lchild + XW'(1);
    assign nlive  = XW'(live_reg);
    assign r_ok   = rchild < nlive;
    assign last   = live_reg - LW'(1);

    always_comb
    begin
        if (r_ok && rd_data.count >= lsl_reg.count)
        begin
            big     = rd_data;
            big_pos = rchild[AW-1:0];
        end
        else
        begin
            big     = lsl_reg;
            big_pos = lchild[AW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        live_next  = live_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        lsl_next   = lsl_reg;
        key_next   = key_reg;
        maxc_next  = maxc_reg;
        first_next = first_reg;
        freq_next  = freq_reg;
        rem_next   = rem_reg;
        full_next  = full_reg;
        ov_next    = ov_reg;
        ofreq_next = ofreq_reg;
        orem_next  = orem_reg;
        ofull_next = ofull_reg;
        olive_next = olive_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = cur_reg;

        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next   = req.value;
                    idx_next   = '0;
                    freq_next  = '0;
                    rem_next   = '0;
                    full_next  = 1'b0;
                    first_next = 1'b1;
                    if (req.operation == OP_ADD)
                        state_next = S_SCAN_RD;
                    else
                        state_next = S_ROOT_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == live_reg)
                begin
                    // value absent: insert at the heap tail or flag full
                    if (live_reg == FULL_LIVE)
                    begin
                        full_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next   = '{key: key_reg, count: COUNT_BITS'(1)};
                        pos_next   = live_reg[AW-1:0];
                        live_next  = live_reg + LW'(1);
                        freq_next  = COUNT_BITS'(1);
                        state_next = S_UP_RD;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (rd_data.key == key_reg)
                begin
                    cur_next.key   = key_reg;
                    cur_next.count = (rd_data.count == CNT_MAX) ? CNT_MAX
                                                                : rd_data.count + 1'b1;
                    freq_next  = cur_next.count;
                    pos_next   = idx_reg[AW-1:0];
                    state_next = S_UP_RD;
                end
                else
                begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data.count >= cur_reg.count)
                    state_next = S_DONE;
                else
                begin
                    // pull the parent down into the hole and climb
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
            end
            S_ROOT_RD:
            begin
                if (live_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_ROOT_CMP;
                end
            end
            S_ROOT_CMP:
            begin
                if (first_reg || rd_data.count == maxc_reg)
                begin
                    if (first_reg)
                    begin
                        maxc_next = rd_data.count;
                        freq_next = rd_data.count;
                    end
                    first_next = 1'b0;
                    rem_next   = rem_reg + LW'(1);
                    live_next  = last;
                    if (last == '0)
                        state_next = S_ROOT_RD;
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = last[AW-1:0];
                        state_next = S_LAST_GET;
                    end
                end
                else
                    state_next = S_DONE;
            end
            S_LAST_GET:
            begin
                cur_next   = rd_data;
                pos_next   = '0;
                state_next = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (lchild >= nlive)
                begin
                    wr_en      = 1'b1;
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lchild[AW-1:0];
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                lsl_next = rd_data;
                if (r_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rchild[AW-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (cur_reg.count >= big.count)
                    state_next = S_ROOT_RD;
                else
                begin
                    // lift the larger child into the hole and sink
                    wr_data    = big;
                    pos_next   = big_pos;
                    state_next = S_DN_RDL;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    ofreq_next = freq_reg;
                    orem_next  = rem_reg;
                    ofull_next = full_reg;
                    olive_next = live_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        lsl_reg   <= lsl_next;
        key_reg   <= key_next;
        maxc_reg  <= maxc_next;
        first_reg <= first_next;
        freq_reg  <= freq_next;
        rem_reg   <= rem_next;
        full_reg  <= full_next;
        ofreq_reg <= ofreq_next;
        orem_reg  <= orem_next;
        ofull_reg <= ofull_next;
        olive_reg <= olive_next;
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = ov_reg;
    assign rsp.freq     = ofreq_reg;
    assign rsp.removed  = orem_reg;
    assign rsp.full_res = ofull_reg;
    assign rsp.live     = olive_reg;

endmodule
